@@ rtl/utfcc_pkg.sv @@
package utfcc_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = QueuePtrW + 1;

    localparam logic [7:0] LowerOffset = 8'h20;

    typedef logic [3:0][7:0] char_bytes_t;

    typedef struct packed {
        char_bytes_t data;
        logic [2:0]  cnt;
    } conv_t;

    typedef struct packed {
        char_bytes_t data;
        logic [2:0]  cnt;
        logic        alpha;
        logic        digit;
        logic        space;
        logic        bad;
    } rec_t;

    function automatic logic trail_ok(input char_bytes_t c, input logic [2:0] n);
        logic ok;
        ok = 1'b1;
        for (int i = 1; i < 4; i++) begin
            if ((i < int'(n)) && (c[i][7:6] != 2'b10)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic conv_t conv_lower(input char_bytes_t c, input logic [2:0] n);
        conv_t      r;
        logic [7:0] a;
        logic [7:0] b;
        a      = c[0];
        b      = c[1];
        r.data = c;
        r.cnt  = n;
        if (n == 3'd1) begin
            if (a inside {[8'h41:8'h5A]}) begin
                r.data[0] = a + LowerOffset;
            end
        end else if (trail_ok(c, n)) begin
            if (n == 3'd2) begin
                if ((a == 8'hC3 && (b inside {[8'h80:8'h96], [8'h98:8'h9E]})) ||
                    (a == 8'hD0 && (b inside {[8'h90:8'h9F]}))) begin
                    r.data[1] = b + LowerOffset;
                end else if (a == 8'hD0 && (b inside {[8'hA0:8'hAF]})) begin
                    r.data[0] = 8'hD1;
                    r.data[1] = b - LowerOffset;
                end else if (a == 8'hD0 && b == 8'h81) begin
                    r.data[0] = 8'hD1;
                    r.data[1] = 8'h91;
                end else if ((a == 8'hC4 && b <= 8'hB7 && !b[0]) ||
                             (a == 8'hC4 && (b inside {[8'hB9:8'hBD]}) && b[0]) ||
                             (a == 8'hC5 && (b inside {[8'h81:8'h87]}) && b[0]) ||
                             (a == 8'hC5 && (b inside {[8'h8A:8'hB7]}) && !b[0]) ||
                             (a == 8'hC5 && (b inside {[8'hB9:8'hBD]}) && b[0])) begin
                    r.data[1] = b + 8'd1;
                end else if (a == 8'hC4 && b == 8'hBF) begin
                    r.data[0] = 8'hC5;
                    r.data[1] = 8'h80;
                end else if (a == 8'hC5 && b == 8'hB8) begin
                    r.data[0] = 8'hC3;
                    r.data[1] = 8'hBF;
                end
            end else if (n == 3'd3 && a == 8'hE1 && b == 8'hBA && c[2] == 8'h9E) begin
                r.data[0] = 8'hC3;
                r.data[1] = 8'h9F;
                r.data[2] = 8'h00;
                r.cnt     = 3'd2;
            end
        end
        return r;
    endfunction

    function automatic conv_t conv_upper(input char_bytes_t c, input logic [2:0] n);
        conv_t      r;
        logic [7:0] a;
        logic [7:0] b;
        a      = c[0];
        b      = c[1];
        r.data = c;
        r.cnt  = n;
        if (n == 3'd1) begin
            if (a inside {[8'h61:8'h7A]}) begin
                r.data[0] = a - LowerOffset;
            end
        end else if (n == 3'd2 && trail_ok(c, n)) begin
            if ((a == 8'hC3 && (b inside {[8'hA0:8'hB6], [8'hB8:8'hBE]})) ||
                (a == 8'hD0 && (b inside {[8'hB0:8'hBF]}))) begin
                r.data[1] = b - LowerOffset;
            end else if (a == 8'hC3 && b == 8'h9F) begin
                r.data[0] = 8'hE1;
                r.data[1] = 8'hBA;
                r.data[2] = 8'h9E;
                r.cnt     = 3'd3;
            end else if (a == 8'hC3 && b == 8'hBF) begin
                r.data[0] = 8'hC5;
                r.data[1] = 8'hB8;
            end else if ((a == 8'hC4 && b <= 8'hB7 && b[0]) ||
                         (a == 8'hC4 && (b inside {[8'hBA:8'hBE]}) && !b[0]) ||
                         (a == 8'hC5 && (b inside {[8'h82:8'h88]}) && !b[0]) ||
                         (a == 8'hC5 && (b inside {[8'h8B:8'hB7]}) && b[0]) ||
                         (a == 8'hC5 && (b inside {[8'hBA:8'hBE]}) && !b[0])) begin
                r.data[1] = b - 8'd1;
            end else if (a == 8'hC5 && b == 8'h80) begin
                r.data[0] = 8'hC4;
                r.data[1] = 8'hBF;
            end else if (a == 8'hD1 && b <= 8'h8F) begin
                r.data[0] = 8'hD0;
                r.data[1] = b + LowerOffset;
            end else if (a == 8'hD1 && b == 8'h91) begin
                r.data[0] = 8'hD0;
                r.data[1] = 8'h81;
            end
        end
        return r;
    endfunction

    function automatic logic alpha_of(input char_bytes_t c, input logic [2:0] n);
        conv_t      low;
        logic [7:0] a;
        logic [7:0] b;
        logic       res;
        low = conv_lower(c, n);
        a   = low.data[0];
        b   = low.data[1];
        res = 1'b0;
        if (n != 3'd1 && !trail_ok(c, n)) begin
            res = 1'b0;
        end else if (low.cnt == 3'd1) begin
            res = (a inside {[8'h61:8'h7A]});
        end else if (low.cnt == 3'd2) begin
            res = (a == 8'hC3 && (b inside {[8'hA0:8'hB6], [8'hB8:8'hBE], 8'h9F, 8'hBF})) ||
                  (a == 8'hC4 && b <= 8'hB7 && b[0]) ||
                  (a == 8'hC4 && (b inside {[8'hBA:8'hBE]}) && !b[0]) ||
                  (a == 8'hC5 && b == 8'h80) ||
                  (a == 8'hC5 && (b inside {[8'h82:8'h88]}) && !b[0]) ||
                  (a == 8'hC5 && (b inside {[8'h8B:8'hB7]}) && b[0]) ||
                  (a == 8'hC5 && (b inside {8'hBA, 8'hBC, 8'hBE})) ||
                  (a == 8'hD0 && (b inside {[8'hB0:8'hBF]})) ||
                  (a == 8'hD1 && (b <= 8'h8F || b == 8'h91));
        end
        return res;
    endfunction

endpackage

@@ rtl/utfcc_front.sv @@
module utfcc_front
    import utfcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       case_mode,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       q_full,
    output logic       q_push,
    output rec_t       q_rec
);

    logic [2:0][7:0] held_reg;
    logic [2:0][7:0] held_next;
    logic [1:0]      seen_reg;
    logic [1:0]      seen_next;
    logic [2:0]      clen_reg;
    logic [2:0]      clen_next;

    logic        accept;
    logic [2:0]  n;
    logic        done;
    char_bytes_t ch;
    conv_t       conv;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        held_next = held_reg;
        seen_next = seen_reg;
        clen_next = clen_reg;
        q_push    = 1'b0;
        done      = 1'b0;
        n         = 3'd1;
        ch        = '0;
        q_rec     = '0;
        if (seen_reg == 2'd0) begin
            if (s_tdata < 8'h80) begin
                n = 3'd1;
            end else if (s_tdata[7:5] == 3'b110) begin
                n = 3'd2;
            end else if (s_tdata[7:4] == 4'b1110) begin
                n = 3'd3;
            end else begin
                n = 3'd4;
            end
        end else begin
            n = clen_reg;
        end
        for (int i = 0; i < 3; i++) begin
            if (i < int'(n) - 1) begin
                ch[i] = held_reg[i];
            end
        end
        ch[2'(n - 3'd1)] = s_tdata;
        conv = case_mode ? conv_upper(ch, n) : conv_lower(ch, n);
        if (accept) begin
            if (seen_reg == 2'd0) begin
                if (s_tdata inside {[8'h80:8'hBF]}) begin
                    q_push        = 1'b1;
                    q_rec.data[0] = s_tdata;
                    q_rec.cnt     = 3'd1;
                    q_rec.bad     = 1'b1;
                end else if (n == 3'd1) begin
                    done = 1'b1;
                end else begin
                    held_next[0] = s_tdata;
                    seen_next    = 2'd1;
                    clen_next    = n;
                end
            end else if ({1'b0, seen_reg} < clen_reg - 3'd1) begin
                for (int i = 1; i < 3; i++) begin
                    if (seen_reg == 2'(i)) begin
                        held_next[i] = s_tdata;
                    end
                end
                seen_next = seen_reg + 2'd1;
            end else begin
                done      = 1'b1;
                seen_next = 2'd0;
                clen_next = 3'd0;
            end
        end
        if (done) begin
            q_push      = 1'b1;
            q_rec.data  = conv.data;
            q_rec.cnt   = conv.cnt;
            q_rec.alpha = alpha_of(ch, n);
            q_rec.digit = (ch[0] inside {[8'h30:8'h39]});
            q_rec.space = (ch[0] == 8'h20) || (ch[0] inside {[8'h09:8'h0D]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            seen_reg <= 2'd0;
            clen_reg <= 3'd0;
        end else begin
            held_reg <= held_next;
            seen_reg <= seen_next;
            clen_reg <= clen_next;
        end
    end

endmodule

@@ rtl/utfcc_queue.sv @@
module utfcc_queue
    import utfcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t wr_rec,
    input  logic pop,
    output rec_t rd_rec,
    output logic full,
    output logic empty
);

    rec_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QueueCntW'(QueueDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QueueCntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QueueCntW'(1);
            end
        end
    end

endmodule

@@ rtl/utfcc_back.sv @@
module utfcc_back
    import utfcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  rec_t       q_rec,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [3:0] m_tuser
);

    rec_t       cur_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;

    assign last     = ({1'b0, idx_reg} == cur_reg.cnt - 3'd1);
    assign q_pop    = !q_empty && (!valid_reg || (m_tready && last));
    assign m_tvalid = valid_reg;
    assign m_tdata  = cur_reg.data[idx_reg];
    assign m_tlast  = last;
    assign m_tuser  = {cur_reg.bad, cur_reg.space, cur_reg.digit, cur_reg.alpha} & {4{last}};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

@@ rtl/utf8_case_converter.sv @@
// UTF-8 case converter: takes one byte per cycle on s_, gathers each character (length
// from its lead byte) and queues the converted character in a four-entry queue; the
// output side sends one byte per cycle on m_ while m_tready is high, m_tlast on a
// character's last byte with the flags in m_tuser. Characters pass a queue entry, then
// cur_reg. Input stalls only when the queue is full, which the output byte rate sets
// (a sharp s in upper mode grows from two bytes to three). case_mode sits at address 0.
module utf8_case_converter
    import utfcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // char_end
    output logic [3:0]  m_tuser,   // is_alpha, is_digit, is_space, bad_lead
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic mode_reg;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    rec_t wr_rec;
    rec_t rd_rec;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            mode_reg <= pwdata[0];
        end
    end

    utfcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .case_mode (mode_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (wr_rec)
    );

    utfcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_rec  (wr_rec),
        .pop     (q_pop),
        .rd_rec  (rd_rec),
        .full    (q_full),
        .empty   (q_empty)
    );

    utfcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rec    (rd_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_flags_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 4'd0) |-> m_tlast)
        else $error("flags set on a byte that does not end a character");

    a_bad_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == 3'd0))
        else $error("stray continuation carries class flags");

    a_stray_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && q_push && wr_rec.bad |=> !q_empty)
        else $error("stray continuation item lost");
`endif

endmodule
